FILE: hw/rtl/selective_repeat_receive_window_unit_assert.svh
// assertion macros for the receive window unit
`ifndef SELECTIVE_REPEAT_RECEIVE_WINDOW_UNIT_ASSERT_SVH
`define SELECTIVE_REPEAT_RECEIVE_WINDOW_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define SRRW_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define SRRW_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`else

`define SRRW_ASSERT_IMPL(label, clk, rst, ante, cons, msg)
`define SRRW_ASSERT_NEXT(label, clk, rst, ante, cons, msg)

`endif

`endif

FILE: hw/rtl/srrw_pkg.sv
`default_nettype none

package srrw_pkg;

   localparam int SLOTS_DEFAULT        = 4;
   localparam int PACKET_BYTES_DEFAULT = 64;
   localparam int WORD_BYTES           = 8;
   localparam int WORD_IDX_W           = 3;
   localparam int LEN_W                = 7;

   typedef enum logic [1:0] {
      KIND_DATA   = 2'd0,
      KIND_ACK    = 2'd1,
      KIND_REJECT = 2'd2
   } kind_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CALC,
      ST_COMMIT,
      ST_FL_SLOT,
      ST_FL_LEN,
      ST_FL_WORD,
      ST_ACK
   } state_type;

   typedef struct packed {
      logic [31:0]           seq_no;
      logic [LEN_W-1:0]      payload_len;
      logic                  is_last_packet;
      logic [WORD_IDX_W-1:0] word_index;
      logic [63:0]           payload_word;
      logic                  word_last;
   } req_type;

   typedef struct packed {
      kind_type    kind;
      logic [31:0] ack_seq;
      logic [63:0] data_word;
      logic [3:0]  data_bytes;
      logic        run_last;
      logic        transfer_done;
   } rsp_type;

   // keeps the low bytes of a word, all of it for a full word
   function automatic logic [63:0] byte_mask(input logic [3:0] bytes);
      logic [63:0] mask;
      if (bytes >= 4'(WORD_BYTES)) begin
         mask = '1;
      end else begin
         mask = (64'(1) << {bytes, 3'b000}) - 64'(1);
      end
      return mask;
   endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/srrw_store.sv
`default_nettype none

module srrw_store #(
   parameter int SLOTS = srrw_pkg::SLOTS_DEFAULT
) (
   input  wire logic                                        clock,
   input  wire logic                                        pay_we,
   input  wire logic [$clog2(SLOTS > 1 ? SLOTS : 2)+2:0]    pay_waddr,
   input  wire logic [63:0]                                 pay_wdata,
   input  wire logic [$clog2(SLOTS > 1 ? SLOTS : 2)+2:0]    pay_raddr,
   output logic      [63:0]                                 pay_rdata,
   input  wire logic                                        len_we,
   input  wire logic [$clog2(SLOTS > 1 ? SLOTS : 2)-1:0]    len_waddr,
   input  wire logic [srrw_pkg::LEN_W-1:0]                  len_wdata,
   input  wire logic [$clog2(SLOTS > 1 ? SLOTS : 2)-1:0]    len_raddr,
   output logic      [srrw_pkg::LEN_W-1:0]                  len_rdata
);

   localparam int SLOT_W = $clog2(SLOTS > 1 ? SLOTS : 2);
   localparam int ADDR_W = SLOT_W + srrw_pkg::WORD_IDX_W;

   logic [63:0]                 pay_mem [2**ADDR_W];
   logic [srrw_pkg::LEN_W-1:0]  len_mem [2**SLOT_W];

   always_ff @(posedge clock) begin
      if (pay_we) begin
         pay_mem[pay_waddr] <= pay_wdata;
      end
      pay_rdata <= pay_mem[pay_raddr];
   end

   always_ff @(posedge clock) begin
      if (len_we) begin
         len_mem[len_waddr] <= len_wdata;
      end
      len_rdata <= len_mem[len_raddr];
   end

endmodule

`default_nettype wire

FILE: hw/rtl/selective_repeat_receive_window_unit.sv
// a word_last item's result shows on rsp_strobe after the CALC and COMMIT states and stage a, or after a flush
// a new item is taken only in idle, when busy is low; a flush walks every slot, reads the
//   length of each filled slot and sends its data words, then sends the acknowledge
// the flush walk goes over the slot length and payload memories
// reset: synchronous; clears window start, done flag and slot flags, not payload
// results cannot be stalled by the receiver
`default_nettype none

`include "selective_repeat_receive_window_unit_assert.svh"

module selective_repeat_receive_window_unit #(
   parameter int SLOTS        = srrw_pkg::SLOTS_DEFAULT,
   parameter int PACKET_BYTES = srrw_pkg::PACKET_BYTES_DEFAULT
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   output logic                   busy,
   input  wire srrw_pkg::req_type req_item,
   output logic                   rsp_strobe,
   output srrw_pkg::rsp_type      rsp_item
);

   localparam int SPAN     = SLOTS * PACKET_BYTES;
   localparam int DIFF_W   = $clog2(SPAN);
   localparam int LOG_PB   = $clog2(PACKET_BYTES);
   localparam int SHIFT    = DIFF_W + LOG_PB;
   localparam int RECIP_W  = DIFF_W + 2;
   localparam int RECIP    = ((1 << SHIFT) + PACKET_BYTES - 1) / PACKET_BYTES;
   localparam int PROD_W   = DIFF_W + RECIP_W;
   localparam int SLOT_W   = $clog2(SLOTS > 1 ? SLOTS : 2);
   localparam int ADDR_W   = SLOT_W + srrw_pkg::WORD_IDX_W;
   localparam int WPS      = (PACKET_BYTES + 7) / 8;
   localparam int LEN_W    = srrw_pkg::LEN_W;
   localparam int WB       = srrw_pkg::WORD_BYTES;

   srrw_pkg::state_type state_ff, state_in;
   srrw_pkg::req_type   req_ff, req_in;
   logic [31:0]         window_ff, window_in;
   logic                done_ff, done_in;
   logic [SLOTS-1:0]    filled_ff, filled_in;
   logic [SLOTS-1:0]    last_ff, last_in;
   logic                inwin_ff, inwin_in;
   logic                below_ff, below_in;
   logic [PROD_W-1:0]   prod_ff, prod_in;
   logic [SLOT_W-1:0]   walk_ff, walk_in;
   logic [LEN_W-1:0]    rem_ff, rem_in;
   logic [3:0]          word_ff, word_in;

   logic                pend_a_ff, pend_a_in;
   srrw_pkg::kind_type  kind_a_ff, kind_a_in;
   logic [3:0]          bytes_a_ff, bytes_a_in;
   logic                last_a_ff, last_a_in;
   logic [31:0]         seq_a_ff, seq_a_in;

   logic                rsp_strobe_ff;
   srrw_pkg::rsp_type   rsp_ff, rsp_in;

   logic                pay_we;
   logic [ADDR_W-1:0]   pay_waddr;
   logic [ADDR_W-1:0]   pay_raddr;
   logic [63:0]         pay_rdata;
   logic                len_we;
   logic [LEN_W-1:0]    len_wdata;
   logic [LEN_W-1:0]    len_rdata;

   logic [32:0]         win_end;
   logic [DIFF_W-1:0]   diff;
   logic [PROD_W-1:0]   quot;
   logic [SLOT_W-1:0]   slot_sel;
   logic [SLOTS-1:0]    slot_hot;
   logic [SLOTS-1:0]    fill_new;
   logic [SLOTS-1:0]    last_new;
   logic                full;
   logic                prefix;
   logic                any_last;
   logic                walk_end;
   logic [3:0]          bytes_cur;

   srrw_store #(
      .SLOTS(SLOTS)
   ) u_store (
      .clock     (clock),
      .pay_we    (pay_we),
      .pay_waddr (pay_waddr),
      .pay_wdata (req_ff.payload_word),
      .pay_raddr (pay_raddr),
      .pay_rdata (pay_rdata),
      .len_we    (len_we),
      .len_waddr (slot_sel),
      .len_wdata (len_wdata),
      .len_raddr (walk_ff),
      .len_rdata (len_rdata)
   );

   // window check and slot index by reciprocal multiply
   assign win_end = {1'b0, window_ff} + 33'(SPAN) - 33'(1);
   assign diff    = DIFF_W'(req_ff.seq_no - window_ff);

   assign quot     = prod_ff >> SHIFT;
   assign slot_sel = (quot >= PROD_W'(SLOTS)) ? SLOT_W'(SLOTS - 1) : quot[SLOT_W-1:0];
   assign slot_hot = SLOTS'(1) << slot_sel;
   assign fill_new = filled_ff | slot_hot;
   assign last_new = (last_ff & ~slot_hot) | (req_ff.is_last_packet ? slot_hot : '0);
   assign full     = &fill_new;
   assign prefix   = (fill_new & (fill_new + SLOTS'(1))) == '0;
   assign any_last = |last_new;

   assign len_wdata = (32'(req_ff.payload_len) > 32'(PACKET_BYTES)) ?
                      LEN_W'(PACKET_BYTES) : req_ff.payload_len;
   assign pay_waddr = {slot_sel, req_ff.word_index};
   assign pay_raddr = {walk_ff, word_ff[srrw_pkg::WORD_IDX_W-1:0]};

   assign walk_end  = walk_ff == SLOT_W'(SLOTS - 1);
   assign bytes_cur = (rem_ff > LEN_W'(WB)) ? 4'(WB) : rem_ff[3:0];

   always_comb begin
      state_in   = state_ff;
      req_in     = req_ff;
      window_in  = window_ff;
      done_in    = done_ff;
      filled_in  = filled_ff;
      last_in    = last_ff;
      inwin_in   = inwin_ff;
      below_in   = below_ff;
      prod_in    = prod_ff;
      walk_in    = walk_ff;
      rem_in     = rem_ff;
      word_in    = word_ff;
      pend_a_in  = 1'b0;
      kind_a_in  = kind_a_ff;
      bytes_a_in = bytes_a_ff;
      last_a_in  = last_a_ff;
      seq_a_in   = seq_a_ff;
      pay_we     = 1'b0;
      len_we     = 1'b0;
      unique case (state_ff)
         srrw_pkg::ST_IDLE: begin
            if (start) begin
               req_in   = req_item;
               state_in = srrw_pkg::ST_CALC;
            end
         end
         srrw_pkg::ST_CALC: begin
            below_in = req_ff.seq_no < window_ff;
            inwin_in = (req_ff.seq_no >= window_ff) && ({1'b0, req_ff.seq_no} <= win_end);
            prod_in  = PROD_W'(diff) * PROD_W'(RECIP);
            state_in = srrw_pkg::ST_COMMIT;
         end
         srrw_pkg::ST_COMMIT: begin
            pay_we   = inwin_ff && (int'(req_ff.word_index) < WPS);
            state_in = srrw_pkg::ST_IDLE;
            if (req_ff.word_last) begin
               pend_a_in  = 1'b1;
               last_a_in  = 1'b1;
               seq_a_in   = req_ff.seq_no;
               bytes_a_in = '0;
               kind_a_in  = (inwin_ff || below_ff) ? srrw_pkg::KIND_ACK :
                                                     srrw_pkg::KIND_REJECT;
               if (inwin_ff) begin
                  len_we    = 1'b1;
                  filled_in = fill_new;
                  last_in   = last_new;
                  if (full || (prefix && any_last)) begin
                     pend_a_in = 1'b0;
                     walk_in   = '0;
                     state_in  = srrw_pkg::ST_FL_SLOT;
                     if (full) begin
                        window_in = window_ff + 32'(SPAN);
                     end
                     if (any_last) begin
                        done_in = 1'b1;
                     end
                  end
               end
            end
         end
         srrw_pkg::ST_FL_SLOT: begin
            if (filled_ff[walk_ff]) begin
               state_in = srrw_pkg::ST_FL_LEN;
            end else if (walk_end) begin
               state_in = srrw_pkg::ST_ACK;
            end else begin
               walk_in = walk_ff + SLOT_W'(1);
            end
         end
         srrw_pkg::ST_FL_LEN: begin
            rem_in  = len_rdata;
            word_in = '0;
            if (len_rdata != '0) begin
               state_in = srrw_pkg::ST_FL_WORD;
            end else if (walk_end) begin
               state_in = srrw_pkg::ST_ACK;
            end else begin
               walk_in  = walk_ff + SLOT_W'(1);
               state_in = srrw_pkg::ST_FL_SLOT;
            end
         end
         srrw_pkg::ST_FL_WORD: begin
            pend_a_in  = 1'b1;
            kind_a_in  = srrw_pkg::KIND_DATA;
            bytes_a_in = bytes_cur;
            last_a_in  = 1'b0;
            seq_a_in   = '0;
            rem_in     = rem_ff - LEN_W'(bytes_cur);
            word_in    = word_ff + 4'd1;
            if (rem_ff <= LEN_W'(WB)) begin
               if (walk_end) begin
                  state_in = srrw_pkg::ST_ACK;
               end else begin
                  walk_in  = walk_ff + SLOT_W'(1);
                  state_in = srrw_pkg::ST_FL_SLOT;
               end
            end
         end
         srrw_pkg::ST_ACK: begin
            pend_a_in  = 1'b1;
            kind_a_in  = srrw_pkg::KIND_ACK;
            bytes_a_in = '0;
            last_a_in  = 1'b1;
            seq_a_in   = req_ff.seq_no;
            filled_in  = '0;
            last_in    = '0;
            state_in   = srrw_pkg::ST_IDLE;
         end
         default: begin
            state_in = srrw_pkg::ST_IDLE;
         end
      endcase
   end

   // output stage, payload read data lines up with stage a
   always_comb begin
      rsp_in.kind          = kind_a_ff;
      rsp_in.run_last      = last_a_ff;
      rsp_in.transfer_done = done_ff;
      if (kind_a_ff == srrw_pkg::KIND_DATA) begin
         rsp_in.ack_seq    = '0;
         rsp_in.data_word  = pay_rdata & srrw_pkg::byte_mask(bytes_a_ff);
         rsp_in.data_bytes = bytes_a_ff;
      end else begin
         rsp_in.ack_seq    = seq_a_ff;
         rsp_in.data_word  = '0;
         rsp_in.data_bytes = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= srrw_pkg::ST_IDLE;
         window_ff     <= '0;
         done_ff       <= 1'b0;
         filled_ff     <= '0;
         last_ff       <= '0;
         pend_a_ff     <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         window_ff     <= window_in;
         done_ff       <= done_in;
         filled_ff     <= filled_in;
         last_ff       <= last_in;
         pend_a_ff     <= pend_a_in;
         rsp_strobe_ff <= pend_a_ff;
      end
   end

   always_ff @(posedge clock) begin
      req_ff     <= req_in;
      inwin_ff   <= inwin_in;
      below_ff   <= below_in;
      prod_ff    <= prod_in;
      walk_ff    <= walk_in;
      rem_ff     <= rem_in;
      word_ff    <= word_in;
      kind_a_ff  <= kind_a_in;
      bytes_a_ff <= bytes_a_in;
      last_a_ff  <= last_a_in;
      seq_a_ff   <= seq_a_in;
      rsp_ff     <= rsp_in;
   end

   assign busy       = state_ff != srrw_pkg::ST_IDLE;
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_item   = rsp_ff;

   `SRRW_ASSERT_IMPL(a_data_bytes, clock, reset, rsp_strobe_ff && rsp_ff.kind == srrw_pkg::KIND_DATA, rsp_ff.data_bytes != 4'd0 && rsp_ff.data_bytes <= 4'(WB), "data item with bad byte count")
   `SRRW_ASSERT_IMPL(a_ack_last, clock, reset, rsp_strobe_ff && rsp_ff.kind != srrw_pkg::KIND_DATA, rsp_ff.run_last, "acknowledge or reject not last of its run")
   `SRRW_ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy, state_ff == srrw_pkg::ST_CALC, "accepted item did not start work")
   `SRRW_ASSERT_NEXT(a_done_sticky, clock, reset, done_ff, done_ff, "done flag dropped")
   `SRRW_ASSERT_IMPL(a_flush_filled, clock, reset, state_ff == srrw_pkg::ST_FL_WORD, filled_ff[walk_ff], "flushing a slot that is not filled")

endmodule

`default_nettype wire
